[sv/smfd_pkg.sv]
// Shared constants and types for the stereo modulated delay block.
package smfd_pkg;

	localparam int BUFFER_DEPTH = 2048;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int POS_W        = ADDR_W + 8;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 19;
	localparam int MUL_A_W  = 34;
	localparam int MUL_B_W  = 21;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		REG_TARGET_AMOUNT = 2'd0,
		REG_TARGET_MIX    = 2'd1,
		REG_SMOOTH_COEF   = 2'd2,
		REG_MAX_MOD_DELAY = 2'd3
	} reg_index_t;

	localparam logic [15:0] UNITY_Q15   = 16'd32768;
	localparam logic [16:0] COEF_MIN    = 17'd7;
	localparam logic [16:0] COEF_MAX    = 17'd65536;
	localparam logic [18:0] MAXMOD_MIN  = 19'd256;
	localparam logic [18:0] MAXMOD_MAX  = 19'((BUFFER_DEPTH - 8) * 256);
	localparam logic [18:0] DELAY_MIN   = 19'd256;
	localparam logic [18:0] DELAY_MAX   = 19'((BUFFER_DEPTH - 4) * 256);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_SA   = 12'b000000000010,
		ST_SM   = 12'b000000000100,
		ST_C1   = 12'b000000001000,
		ST_C2   = 12'b000000010000,
		ST_C3   = 12'b000000100000,
		ST_C4   = 12'b000001000000,
		ST_C5   = 12'b000010000000,
		ST_C6   = 12'b000100000000,
		ST_C7   = 12'b001000000000,
		ST_C8   = 12'b010000000000,
		ST_C9   = 12'b100000000000
	} state_t;

endpackage

[sv/smfd_if.sv]
// Handshake channel interfaces for the input and result streams.
interface smfd_in_if;
	logic             valid;
	logic             ready;
	smfd_pkg::sample_t in_left;
	smfd_pkg::sample_t in_right;
	smfd_pkg::sample_t mod_left;
	smfd_pkg::sample_t mod_right;

	modport source (output valid, in_left, in_right, mod_left, mod_right, input ready);
	modport sink (input valid, in_left, in_right, mod_left, mod_right, output ready);
endinterface

interface smfd_out_if;
	logic             valid;
	logic             ready;
	smfd_pkg::sample_t out_left;
	smfd_pkg::sample_t out_right;

	modport source (output valid, out_left, out_right, input ready);
	modport sink (input valid, out_left, out_right, output ready);
endinterface

[sv/smfd_mul.sv]
// Shared signed multiplier with a registered product.
module smfd_mul (
	input  logic                                  clk,
	input  logic signed [smfd_pkg::MUL_A_W-1:0]   a,
	input  logic signed [smfd_pkg::MUL_B_W-1:0]   b,
	output logic signed [smfd_pkg::MUL_P_W-1:0]   p
);
	logic signed [smfd_pkg::MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= smfd_pkg::MUL_P_W'(a) * smfd_pkg::MUL_P_W'(b);
	end

	assign p = p_q;
endmodule

[sv/stereo_modulated_delay_fm.sv]
// Top level of the stereo modulated fractional delay with one shared multiplier.
//
// Usage: din carries one request per stereo sample (in_left, in_right and the
// two modulator samples); dout returns one mixed stereo pair per request.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must do so only while idle, as the block does not enforce it. A request is
// written into both delay memories at the edge that accepts it. States SA and
// SM then start smoothing amount and mix, and C1 to C9 run once per channel
// through the shared multiplier and single memory read ports before dout.valid
// rises. din.ready is high only in idle, so no request is taken mid-sequence.
// A finished pair waits in the output register; while the receiver stalls,
// the sequencer stays in idle and takes no new request until that register
// is emptied, so a finished pair never has to wait inside the sequence.
// Reset clears the sequencer, the write position, the smoothed amount and
// mix, and loads the register defaults. The delay memories are not cleared:
// a wrap flag and the write position mark which entries were written, and
// an entry never written reads as zero, so no clearing pass is needed.
module stereo_modulated_delay_fm (
	input  logic                           clk,
	input  logic                           arst_n,
	smfd_in_if.sink                        din,
	smfd_out_if.source                     dout,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [smfd_pkg::CFG_W-1:0]     cfg_data
);
	localparam int AW = smfd_pkg::ADDR_W;
	localparam int PW = smfd_pkg::POS_W;

	smfd_pkg::state_t state_q;
	logic             ch_q;

	logic [15:0] tgt_amt_q, tgt_mix_q;
	logic [16:0] coef_q;
	logic [18:0] maxmod_q;

	logic [31:0] cur_amt_q, cur_mix_q;
	logic [AW-1:0] wp_q;
	logic          wrap_q;

	smfd_pkg::sample_t in_l_q, in_r_q, mod_l_q, mod_r_q;
	logic [PW-1:0]     pos_q;
	logic signed [16:0] a_q;
	smfd_pkg::sample_t  out_l_hold_q;

	logic               out_vld_q;
	smfd_pkg::sample_t  out_l_q, out_r_q;

	smfd_pkg::sample_t mem_l [smfd_pkg::BUFFER_DEPTH];
	smfd_pkg::sample_t mem_r [smfd_pkg::BUFFER_DEPTH];
	smfd_pkg::sample_t rd_l_q, rd_r_q;
	logic              rd_vld_q;
	logic [AW-1:0]     rd_addr;

	logic signed [smfd_pkg::MUL_A_W-1:0] mul_a;
	logic signed [smfd_pkg::MUL_B_W-1:0] mul_b;
	logic signed [smfd_pkg::MUL_P_W-1:0] prod;

	logic        accept;
	logic        finish;
	logic [15:0] amt, mix;
	logic [15:0] tgt_amt_c, tgt_mix_c;
	logic [16:0] coef_c;
	logic [18:0] maxmod_c;
	smfd_pkg::sample_t in_c, mod_c, rd_c;
	logic signed [16:0] rd_m;
	logic [31:0] smooth_res;
	logic [PW-1:0] pos_c;
	logic signed [16:0] delayed_c;
	smfd_pkg::sample_t wet_c, out_c;

	function automatic logic [31:0] smooth_next(input logic [31:0] cur,
			input logic signed [smfd_pkg::MUL_P_W-1:0] p);
		logic signed [smfd_pkg::MUL_P_W-1:0] r;
		logic signed [40:0] n;
		r = (p + smfd_pkg::MUL_P_W'(32768)) >>> 16;
		n = 41'($signed({1'b0, cur})) + 41'(r);
		if (n < 41'sd0) begin
			smooth_next = 32'd0;
		end else if (n > 41'sh0080000000) begin
			smooth_next = 32'h8000_0000;
		end else begin
			smooth_next = n[31:0];
		end
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
		if (v > 41'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (v < -41'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

	smfd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign accept = din.valid && din.ready;
	// A request is only taken when the output register is free by the time it finishes.
	assign din.ready = (state_q == smfd_pkg::ST_IDLE) && (!out_vld_q || dout.ready);
	assign finish = (state_q == smfd_pkg::ST_C9) && ch_q;

	assign dout.valid     = out_vld_q;
	assign dout.out_left  = out_l_q;
	assign dout.out_right = out_r_q;

	// Register clamps.
	assign tgt_amt_c = (tgt_amt_q > smfd_pkg::UNITY_Q15) ? smfd_pkg::UNITY_Q15 : tgt_amt_q;
	assign tgt_mix_c = (tgt_mix_q > smfd_pkg::UNITY_Q15) ? smfd_pkg::UNITY_Q15 : tgt_mix_q;
	assign coef_c = (coef_q < smfd_pkg::COEF_MIN) ? smfd_pkg::COEF_MIN :
		(coef_q > smfd_pkg::COEF_MAX) ? smfd_pkg::COEF_MAX : coef_q;
	assign maxmod_c = (maxmod_q < smfd_pkg::MAXMOD_MIN) ? smfd_pkg::MAXMOD_MIN :
		(maxmod_q > smfd_pkg::MAXMOD_MAX) ? smfd_pkg::MAXMOD_MAX : maxmod_q;

	assign amt = 16'((33'(cur_amt_q) + 33'd32768) >> 16);
	assign mix = 16'((33'(cur_mix_q) + 33'd32768) >> 16);

	assign in_c  = ch_q ? in_r_q : in_l_q;
	assign mod_c = ch_q ? mod_r_q : mod_l_q;
	assign rd_c  = ch_q ? rd_r_q : rd_l_q;
	// Entries never written since reset read as zero.
	assign rd_m  = rd_vld_q ? 17'(rd_c) : 17'sd0;

	always_comb begin
		logic signed [smfd_pkg::MUL_P_W-1:0] t;
		logic signed [25:0] dly;
		logic signed [32:0] d;
		mul_a      = '0;
		mul_b      = '0;
		rd_addr    = pos_q[PW-1:8];
		smooth_res = smooth_next(cur_amt_q, prod);
		pos_c      = '0;
		delayed_c  = '0;
		wet_c      = '0;
		out_c      = '0;
		t          = '0;
		dly        = '0;
		d          = '0;
		unique case (state_q)
			smfd_pkg::ST_IDLE: begin
			end
			smfd_pkg::ST_SA: begin
				d = $signed({1'b0, tgt_amt_c, 16'd0}) - $signed({1'b0, cur_amt_q});
				mul_a = 34'(d);
				mul_b = $signed({4'd0, coef_c});
			end
			smfd_pkg::ST_SM: begin
				d = $signed({1'b0, tgt_mix_c, 16'd0}) - $signed({1'b0, cur_mix_q});
				mul_a = 34'(d);
				mul_b = $signed({4'd0, coef_c});
			end
			smfd_pkg::ST_C1: begin
				smooth_res = smooth_next(cur_mix_q, prod);
				mul_a = 34'(mod_c);
				mul_b = $signed({5'd0, amt});
			end
			smfd_pkg::ST_C2: begin
				mul_a = 34'($signed(prod[31:0]));
				mul_b = $signed({2'd0, maxmod_c});
			end
			smfd_pkg::ST_C3: begin
				t = (prod + (smfd_pkg::MUL_P_W'(1) <<< 29)) >>> 30;
				dly = $signed({7'd0, maxmod_c}) + 26'sd512 + 26'(t);
				if (dly < $signed({7'd0, smfd_pkg::DELAY_MIN})) begin
					dly = $signed({7'd0, smfd_pkg::DELAY_MIN});
				end else if (dly > $signed({7'd0, smfd_pkg::DELAY_MAX})) begin
					dly = $signed({7'd0, smfd_pkg::DELAY_MAX});
				end
				pos_c = {wp_q, 8'd0} - dly[PW-1:0];
			end
			smfd_pkg::ST_C4: begin
				rd_addr = pos_q[PW-1:8];
			end
			smfd_pkg::ST_C5: begin
				rd_addr = pos_q[PW-1:8] + AW'(1);
			end
			smfd_pkg::ST_C6: begin
				mul_a = 34'(rd_m - a_q);
				mul_b = $signed({13'd0, pos_q[7:0]});
			end
			smfd_pkg::ST_C7: begin
				t = (prod + smfd_pkg::MUL_P_W'(128)) >>> 8;
				delayed_c = a_q + 17'(t);
				mul_a = 34'(delayed_c) - 34'(in_c);
				mul_b = $signed({5'd0, amt});
			end
			smfd_pkg::ST_C8: begin
				t = (prod + smfd_pkg::MUL_P_W'(16384)) >>> 15;
				wet_c = sat16(41'(in_c) + 41'(t));
				mul_a = 34'(wet_c) - 34'(in_c);
				mul_b = $signed({5'd0, mix});
			end
			smfd_pkg::ST_C9: begin
				t = ((smfd_pkg::MUL_P_W'(in_c) <<< 15) + prod
					+ smfd_pkg::MUL_P_W'(16384)) >>> 15;
				out_c = sat16(41'(t));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_amt_q <= '0;
			tgt_mix_q <= '0;
			coef_q    <= 17'd148;
			maxmod_q  <= 19'd56448;
		end else if (cfg_we) begin
			unique case (smfd_pkg::reg_index_t'(cfg_index))
				smfd_pkg::REG_TARGET_AMOUNT: tgt_amt_q <= cfg_data[15:0];
				smfd_pkg::REG_TARGET_MIX:    tgt_mix_q <= cfg_data[15:0];
				smfd_pkg::REG_SMOOTH_COEF:   coef_q    <= cfg_data[16:0];
				smfd_pkg::REG_MAX_MOD_DELAY: maxmod_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= smfd_pkg::ST_IDLE;
			ch_q      <= 1'b0;
			cur_amt_q <= '0;
			cur_mix_q <= '0;
			wp_q      <= '0;
			wrap_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				smfd_pkg::ST_IDLE: begin
					ch_q <= 1'b0;
					if (accept) begin
						state_q <= smfd_pkg::ST_SA;
					end
				end
				smfd_pkg::ST_SA: state_q <= smfd_pkg::ST_SM;
				smfd_pkg::ST_SM: begin
					cur_amt_q <= smooth_res;
					state_q   <= smfd_pkg::ST_C1;
				end
				smfd_pkg::ST_C1: begin
					if (!ch_q) begin
						cur_mix_q <= smooth_res;
					end
					state_q <= smfd_pkg::ST_C2;
				end
				smfd_pkg::ST_C2: state_q <= smfd_pkg::ST_C3;
				smfd_pkg::ST_C3: state_q <= smfd_pkg::ST_C4;
				smfd_pkg::ST_C4: state_q <= smfd_pkg::ST_C5;
				smfd_pkg::ST_C5: state_q <= smfd_pkg::ST_C6;
				smfd_pkg::ST_C6: state_q <= smfd_pkg::ST_C7;
				smfd_pkg::ST_C7: state_q <= smfd_pkg::ST_C8;
				smfd_pkg::ST_C8: state_q <= smfd_pkg::ST_C9;
				smfd_pkg::ST_C9: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= smfd_pkg::ST_C1;
					end else begin
						wp_q <= wp_q + AW'(1);
						if (wp_q == AW'(smfd_pkg::BUFFER_DEPTH - 1)) begin
							wrap_q <= 1'b1;
						end
						state_q <= smfd_pkg::ST_IDLE;
					end
				end
				default: state_q <= smfd_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_l_q  <= din.in_left;
			in_r_q  <= din.in_right;
			mod_l_q <= din.mod_left;
			mod_r_q <= din.mod_right;
		end
		if (state_q == smfd_pkg::ST_C3) begin
			pos_q <= pos_c;
		end
		if (state_q == smfd_pkg::ST_C5) begin
			a_q <= rd_m;
		end
		if (state_q == smfd_pkg::ST_C9 && !ch_q) begin
			out_l_hold_q <= out_c;
		end
		if (finish) begin
			out_l_q <= out_l_hold_q;
			out_r_q <= out_c;
		end
	end

	// Delay memories: written on acceptance, read one address per cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_l[wp_q] <= din.in_left;
			mem_r[wp_q] <= din.in_right;
		end
		rd_l_q   <= mem_l[rd_addr];
		rd_r_q   <= mem_r[rd_addr];
		rd_vld_q <= wrap_q || (rd_addr <= wp_q);
	end
endmodule

[test/tb_smfd_if.sv]
// Timescale for the testbench; the handshake interfaces come from sv/smfd_if.sv.
`timescale 1ns / 1ps

[test/tb_stereo_modulated_delay_fm.sv]
// Testbench for the stereo modulated delay: predicts each output pair and checks it.
`timescale 1ns / 1ps
module tb_stereo_modulated_delay_fm;

	localparam int DEPTH = smfd_pkg::BUFFER_DEPTH;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [smfd_pkg::CFG_W-1:0] cfg_data;

	smfd_in_if din ();
	smfd_out_if dout ();

	stereo_modulated_delay_fm u_dut (
		.clk(clk), .arst_n(arst_n), .din(din.sink), .dout(dout.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] r;
	} pair_t;

	// Predictor state.
	logic signed [15:0] echo_l [DEPTH];
	logic signed [15:0] echo_r [DEPTH];
	int unsigned wr_pos;
	longint cur_amount, cur_mix;
	logic [15:0] tgt_amount, tgt_mix;
	logic [16:0] coef_reg;
	logic [18:0] excursion_reg;

	pair_t expected_pairs[$];
	int errors;
	int send_idle_pct, recv_stall_pct;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint round_sh(longint x, int n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint smooth_step(longint cur, longint tgt, longint k);
		longint t, n;
		t = (tgt > 32768 ? 32768 : tgt) <<< 16;
		n = cur + round_sh((t - cur) * k, 16);
		if (n < 0) n = 0;
		if (n > (longint'(32768) <<< 16)) n = longint'(32768) <<< 16;
		return n;
	endfunction

	function automatic longint chan_out(bit right, longint x, longint m, longint amt,
			longint mix, longint maxmod);
		longint exc, dly, pos, a, b, dl, wet;
		int ia, ib, fr;
		exc = round_sh(m * amt * maxmod, 30);
		dly = maxmod + 512 + exc;
		if (dly < 256) dly = 256;
		if (dly > (DEPTH - 4) * 256) dly = (DEPTH - 4) * 256;
		pos = longint'(wr_pos) * 256 - dly;
		if (pos < 0) pos += DEPTH * 256;
		ia = int'(pos >>> 8) % DEPTH;
		fr = int'(pos & 255);
		ib = (ia + 1) % DEPTH;
		a = right ? echo_r[ia] : echo_l[ia];
		b = right ? echo_r[ib] : echo_l[ib];
		dl = a + round_sh((b - a) * fr, 8);
		wet = clip16(x + round_sh((dl - x) * amt, 15));
		return clip16(round_sh(x * (32768 - mix) + wet * mix, 15));
	endfunction

	function automatic pair_t predict_pair(logic signed [15:0] il, logic signed [15:0] ir,
			logic signed [15:0] ml, logic signed [15:0] mr);
		longint k, mm, amt, mix;
		pair_t p;
		k = coef_reg;
		mm = excursion_reg;
		if (k < 7) k = 7;
		if (k > 65536) k = 65536;
		if (mm < 256) mm = 256;
		if (mm > (DEPTH - 8) * 256) mm = (DEPTH - 8) * 256;
		cur_amount = smooth_step(cur_amount, tgt_amount, k);
		cur_mix = smooth_step(cur_mix, tgt_mix, k);
		amt = (cur_amount + 32768) >>> 16;
		mix = (cur_mix + 32768) >>> 16;
		echo_l[wr_pos] = il;
		echo_r[wr_pos] = ir;
		p.l = 16'(chan_out(0, il, ml, amt, mix, mm));
		p.r = 16'(chan_out(1, ir, mr, amt, mix, mm));
		wr_pos = (wr_pos + 1) % DEPTH;
		return p;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Result checker with random receiver stalls.
	always @(posedge clk) begin
		pair_t e;
		if (arst_n) begin
			if (dout.valid && dout.ready) begin
				if (expected_pairs.size() == 0) begin
					report_mismatch("unexpected output", dout.out_left, 0);
				end else begin
					e = expected_pairs.pop_front();
					if (dout.out_left !== e.l) report_mismatch("out_left", dout.out_left, e.l);
					if (dout.out_right !== e.r)
						report_mismatch("out_right", dout.out_right, e.r);
				end
			end
			dout.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Valid stays high after a request is taken; wait_drained or an idle gap in the next call lowers it.
	task automatic send_request(logic signed [15:0] il, logic signed [15:0] ir,
			logic signed [15:0] ml, logic signed [15:0] mr);
		while ($urandom_range(99) < send_idle_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.in_left <= il;
		din.in_right <= ir;
		din.mod_left <= ml;
		din.mod_right <= mr;
		do @(posedge clk); while (!din.ready);
		expected_pairs.push_back(predict_pair(il, ir, ml, mr));
	endtask

	task automatic wait_drained();
		din.valid <= 1'b0;
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(smfd_pkg::reg_index_t idx, logic [smfd_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			smfd_pkg::REG_TARGET_AMOUNT: tgt_amount = val[15:0];
			smfd_pkg::REG_TARGET_MIX: tgt_mix = val[15:0];
			smfd_pkg::REG_SMOOTH_COEF: coef_reg = val[16:0];
			default: excursion_reg = val[18:0];
		endcase
	endtask

	function automatic logic [15:0] edge_sample();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		// Extremes with defaults, then fully wet at full amount and fastest smoothing.
		send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
		send_request(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		send_request(0, 0, 0, 0);
		wait_drained();
		write_reg(smfd_pkg::REG_TARGET_AMOUNT, 19'd32768);
		write_reg(smfd_pkg::REG_TARGET_MIX, 19'd32768);
		write_reg(smfd_pkg::REG_SMOOTH_COEF, 19'd65536);
		write_reg(smfd_pkg::REG_MAX_MOD_DELAY, 19'd256);
		// Tiny excursion with negative mod reads the shortest delay, two samples behind the slot just written.
		for (int i = 0; i < 8; i++)
			send_request(16'(i * 4000 - 16000), 16'(-i * 3000), 16'sh8000, 16'sh7FFF);
		wait_drained();
		// Out of range targets, coefficient and excursion are clamped.
		write_reg(smfd_pkg::REG_TARGET_AMOUNT, 19'hFFFF);
		write_reg(smfd_pkg::REG_TARGET_MIX, 19'd40000);
		write_reg(smfd_pkg::REG_SMOOTH_COEF, 19'd0);
		write_reg(smfd_pkg::REG_MAX_MOD_DELAY, 19'h7FFFF);
		for (int i = 0; i < 6; i++)
			send_request(edge_sample(), edge_sample(), edge_sample(), edge_sample());
		wait_drained();
		write_reg(smfd_pkg::REG_SMOOTH_COEF, 19'h1FFFF);
		write_reg(smfd_pkg::REG_MAX_MOD_DELAY, 19'd0);
		for (int i = 0; i < 6; i++)
			send_request(edge_sample(), edge_sample(), edge_sample(), edge_sample());
		wait_drained();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0) begin
				wait_drained();
				write_reg(smfd_pkg::REG_TARGET_AMOUNT, 19'($urandom_range(40000)));
				write_reg(smfd_pkg::REG_TARGET_MIX, 19'($urandom_range(40000)));
				write_reg(smfd_pkg::REG_SMOOTH_COEF, ($urandom_range(3) == 0) ? 19'd65536
					: 19'($urandom_range(70000)));
				write_reg(smfd_pkg::REG_MAX_MOD_DELAY, ($urandom_range(3) == 0) ? 19'd522240
					: 19'($urandom_range(524287)));
			end
			send_request(edge_sample(), edge_sample(), edge_sample(), edge_sample());
		end
		wait_drained();
	endtask

	initial begin
		errors = 0;
		wr_pos = 0;
		cur_amount = 0;
		cur_mix = 0;
		tgt_amount = 0;
		tgt_mix = 0;
		coef_reg = 17'd148;
		excursion_reg = 19'd56448;
		for (int i = 0; i < DEPTH; i++) begin
			echo_l[i] = 0;
			echo_r[i] = 0;
		end
		send_idle_pct = 25;
		recv_stall_pct = 54;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		din.valid = 0;
		din.in_left = 0;
		din.in_right = 0;
		din.mod_left = 0;
		din.mod_right = 0;
		dout.ready = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600);
		send_idle_pct = 54;
		recv_stall_pct = 25;
		test_random(600);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(600);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
